// ===== sv/s2l_pkg.sv =====
// s2l_pkg: shared types, fixed constants and elaboration-time table builders
// for the sRGB to CIELAB pipeline. No dependencies.
package s2l_pkg;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   // sRGB to XYZ matrix, units of 1e-7
   localparam logic [23:0] MAT [3][3] = '{
      '{24'd4124564, 24'd3575761, 24'd1804375},
      '{24'd2126729, 24'd7151522, 24'd721750},
      '{24'd193339,  24'd1191920, 24'd9503041}
   };

   // Ratio divisor: 10 * 65535 * white (white in units of 1e-6)
   localparam logic [63:0] DEN_X = 64'd655350 * 64'd950456;
   localparam logic [63:0] DEN_Y = 64'd655350 * 64'd1000000;
   localparam logic [63:0] DEN_Z = 64'd655350 * 64'd1088754;

   localparam logic [39:0] DEN [3] = '{40'(DEN_X), 40'(DEN_Y), 40'(DEN_Z)};
   localparam logic [41:0] TWICE_DEN [3] = '{42'(DEN_X << 1), 42'(DEN_Y << 1), 42'(DEN_Z << 1)};
   localparam logic [38:0] HALF_DEN [3] = '{39'(DEN_X >> 1), 39'(DEN_Y >> 1), 39'(DEN_Z >> 1)};
   // Reciprocal estimate: floor(2^60 / den)
   localparam logic [20:0] RECIP [3] = '{
      21'((64'd1 << 60) / DEN_X),
      21'((64'd1 << 60) / DEN_Y),
      21'((64'd1 << 60) / DEN_Z)
   };

   localparam logic [20:0] ONE_Q20 = 21'd1048576;
   // Largest ratio on the linear segment of f
   localparam logic [20:0] EPS_RATIO = 21'((64'd8856 << 20) / 64'd1000000);
   // Linear segment: (9033*r + 160*2^20 + 580) / 1160
   localparam logic [28:0] LIN_BIAS = 29'd167772740;
   localparam logic [28:0] LIN_SLOPE = 29'd9033;
   localparam logic [29:0] LIN_MAGIC = 30'(((64'd1 << 40) + 64'd1159) / 64'd1160);

   function automatic logic [63:0] mul31(input logic [63:0] a, input logic [63:0] b);
      return (a * b + (64'd1 << 30)) >> 31;
   endfunction

   function automatic logic [63:0] pow5(input logic [63:0] y);
      logic [63:0] y2;
      logic [63:0] y4;
      y2 = mul31(y, y);
      y4 = mul31(y2, y2);
      return mul31(y4, y);
   endfunction

   // Gamma decode of one 8-bit code to a 16-bit linear fraction
   function automatic logic [15:0] gamma_decode(input int unsigned v);
      logic [63:0] u;
      logic [63:0] q;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] lin;
      if (v <= 10) begin
         lin = (64'd6553500 * 64'(v) + 64'd164730) / 64'd329460;
         return lin[15:0];
      end
      u = ((64'(1000 * v + 14025) << 31) + 64'd134512) / 64'd269025;
      q = mul31(u, u);
      lo = 64'd0;
      hi = (64'd1 << 31) + 64'd1;
      while (hi - lo > 64'd1) begin
         mid = lo + ((hi - lo) >> 1);
         if (pow5(mid) <= q) lo = mid;
         else hi = mid;
      end
      lin = (mul31(q, lo) * 64'd65535 + (64'd1 << 30)) >> 31;
      if (lin > 64'd65535) lin = 64'd65535;
      return lin[15:0];
   endfunction

   // Cube-root table entry: largest Q20 y with y^3 <= i * 2^(60-bits)
   function automatic logic [20:0] root_entry(input int unsigned i, input int unsigned bits);
      logic [63:0] target;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      target = 64'(i) << (60 - bits);
      lo = 64'd0;
      hi = (64'd1 << 20) + 64'd2;
      while (hi - lo > 64'd1) begin
         mid = lo + ((hi - lo) >> 1);
         if (mid * mid * mid <= target) lo = mid;
         else hi = mid;
      end
      return lo[20:0];
   endfunction

endpackage

// ===== sv/s2l_if.sv =====
// s2l_if: valid/ready channel interfaces for pixels in and Lab results out.
// No dependencies.
interface s2l_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last_in;

   modport source (output valid, red, green, blue, last_in, input ready);
   modport sink (input valid, red, green, blue, last_in, output ready);
endinterface

interface s2l_rsp_if;
   logic               valid;
   logic               ready;
   logic        [14:0] lightness;
   logic signed [15:0] green_red;
   logic signed [15:0] blue_yellow;
   logic               last_out;

   modport source (output valid, lightness, green_red, blue_yellow, last_out, input ready);
   modport sink (input valid, lightness, green_red, blue_yellow, last_out, output ready);
endinterface

// ===== sv/s2l_gamma_matrix.sv =====
// s2l_gamma_matrix: gamma table lookup and 3x3 matrix accumulate (three stages).
// Depends on s2l_pkg.
module s2l_gamma_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  s2l_pkg::ctl_type   ctl_in,
   input  logic [7:0]         red,
   input  logic [7:0]         green,
   input  logic [7:0]         blue,
   output s2l_pkg::ctl_type   ctl_out,
   output logic [2:0][39:0]   acc_out
);

   logic [15:0] gamma_rom [256];

   for (genvar g = 0; g < 256; g++) begin : g_gamma
      localparam logic [15:0] ENTRY = s2l_pkg::gamma_decode(g);
      assign gamma_rom[g] = ENTRY;
   end

   s2l_pkg::ctl_type ctl1_ff, ctl2_ff, ctl3_ff;
   logic [2:0][15:0]       lin_in, lin_ff;
   logic [2:0][2:0][39:0]  prod_in, prod_ff;
   logic [2:0][39:0]       acc_in, acc_ff;

   always_comb begin
      lin_in[0] = gamma_rom[red];
      lin_in[1] = gamma_rom[green];
      lin_in[2] = gamma_rom[blue];
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[r][j] = {16'd0, s2l_pkg::MAT[r][j]} * {24'd0, lin_ff[j]};
         end
         acc_in[r] = prod_ff[r][0] + prod_ff[r][1] + prod_ff[r][2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_ff  <= lin_in;
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

   assign ctl_out = ctl3_ff;
   assign acc_out = acc_ff;

endmodule

// ===== sv/s2l_ratio.sv =====
// s2l_ratio: divide each accumulator by its white-point constant, rounded and
// clamped to Q20 (four stages). Depends on s2l_pkg.
module s2l_ratio (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  s2l_pkg::ctl_type   ctl_in,
   input  logic [2:0][39:0]   acc_in,
   output s2l_pkg::ctl_type   ctl_out,
   output logic [2:0][20:0]   ratio_out
);

   s2l_pkg::ctl_type ctl4_ff, ctl5_ff, ctl6_ff, ctl7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
         ctl7_ff <= '0;
      end else if (adv) begin
         ctl4_ff <= ctl_in;
         ctl5_ff <= ctl4_ff;
         ctl6_ff <= ctl5_ff;
         ctl7_ff <= ctl6_ff;
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_row
      localparam logic [19:0] DEN_LO = s2l_pkg::DEN[g][19:0];
      localparam logic [19:0] DEN_HI = s2l_pkg::DEN[g][39:20];

      logic [44:0] est_prod;
      logic [20:0] q4_in, q4_ff, q5_ff, q6_ff;
      logic [41:0] n4_in, n4_ff, n5_ff;
      logic [40:0] lo_prod_in, lo_prod_ff;
      logic [40:0] hi_prod;
      logic [21:0] hi_prod_in, hi_prod_ff;
      logic [41:0] rem_in, rem_ff;
      logic [20:0] q_fix;
      logic [20:0] ratio_in, ratio_ff;

      always_comb begin
         // Underestimate of the quotient from the top accumulator bits
         est_prod = {21'd0, acc_in[g][39:16]} * {24'd0, s2l_pkg::RECIP[g]};
         q4_in = est_prod[44:24];
         n4_in = {acc_in[g][21:0], 20'd0} + {3'd0, s2l_pkg::HALF_DEN[g]};
         // Low 42 bits of quotient times divisor, in two partial products
         lo_prod_in = {20'd0, q4_ff} * {21'd0, DEN_LO};
         hi_prod = {20'd0, q4_ff} * {21'd0, DEN_HI};
         hi_prod_in = hi_prod[21:0];
         rem_in = n5_ff - {1'b0, lo_prod_ff} - {hi_prod_ff, 20'd0};
         // Remainder is below three divisors: step the quotient up at most twice
         if (rem_ff >= s2l_pkg::TWICE_DEN[g]) q_fix = q6_ff + 21'd2;
         else if (rem_ff >= {2'd0, s2l_pkg::DEN[g]}) q_fix = q6_ff + 21'd1;
         else q_fix = q6_ff;
         ratio_in = (q_fix > s2l_pkg::ONE_Q20) ? s2l_pkg::ONE_Q20 : q_fix;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q4_ff      <= q4_in;
            n4_ff      <= n4_in;
            q5_ff      <= q4_ff;
            n5_ff      <= n4_ff;
            lo_prod_ff <= lo_prod_in;
            hi_prod_ff <= hi_prod_in;
            q6_ff      <= q5_ff;
            rem_ff     <= rem_in;
            ratio_ff   <= ratio_in;
         end
      end

      assign ratio_out[g] = ratio_ff;
   end

   assign ctl_out = ctl7_ff;

endmodule

// ===== sv/s2l_cie_f.sv =====
// s2l_cie_f: CIE f function per channel, cube-root table with interpolation
// or linear segment (three stages). Depends on s2l_pkg.
module s2l_cie_f #(
   parameter int ROOT_TABLE_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  s2l_pkg::ctl_type   ctl_in,
   input  logic [2:0][20:0]   ratio_in,
   output s2l_pkg::ctl_type   ctl_out,
   output logic [2:0][20:0]   f_out
);

   localparam int ROOT_SIZE = 1 << ROOT_TABLE_BITS;
   localparam int RS        = 20 - ROOT_TABLE_BITS;
   localparam int IDX_W     = ROOT_TABLE_BITS + 1;
   localparam int DP_W      = 21 + RS;
   localparam logic [DP_W-1:0] HALF_FR = DP_W'(1) << (RS - 1);

   s2l_pkg::ctl_type ctl8_ff, ctl9_ff, ctl10_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl8_ff  <= '0;
         ctl9_ff  <= '0;
         ctl10_ff <= '0;
      end else if (adv) begin
         ctl8_ff  <= ctl_in;
         ctl9_ff  <= ctl8_ff;
         ctl10_ff <= ctl9_ff;
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      logic [20:0] root_rom [ROOT_SIZE+1];

      for (genvar e = 0; e <= ROOT_SIZE; e++) begin : g_rom
         localparam logic [20:0] ENTRY = s2l_pkg::root_entry(e, ROOT_TABLE_BITS);
         assign root_rom[e] = ENTRY;
      end

      logic [IDX_W-1:0] idx, idx_next;
      logic [20:0]      base_ff, next_ff, base9_ff;
      logic [RS-1:0]    fr_in, fr_ff;
      logic             use_in, use8_ff, use9_ff;
      logic [28:0]      lnum_in, lnum_ff;
      logic [20:0]      diff;
      logic [DP_W-1:0]  dprod_in, dprod_ff, rnd;
      logic [58:0]      lprod_in, lprod_ff;
      logic [20:0]      f_in, f_ff;

      always_comb begin
         idx      = ratio_in[g][20:RS];
         // Full scale has no upper neighbor; its fraction is zero anyway
         idx_next = (idx == IDX_W'(ROOT_SIZE)) ? idx : idx + 1'b1;
         fr_in    = ratio_in[g][RS-1:0];
         use_in   = ratio_in[g] > s2l_pkg::EPS_RATIO;
         lnum_in  = {15'd0, ratio_in[g][13:0]} * s2l_pkg::LIN_SLOPE + s2l_pkg::LIN_BIAS;
         diff     = next_ff - base_ff;
         dprod_in = {{RS{1'b0}}, diff} * {21'd0, fr_ff};
         lprod_in = {30'd0, lnum_ff} * {29'd0, s2l_pkg::LIN_MAGIC};
         rnd      = dprod_ff + HALF_FR;
         f_in     = use9_ff ? base9_ff + rnd[DP_W-1:RS] : {2'd0, lprod_ff[58:40]};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            base_ff  <= root_rom[idx];
            next_ff  <= root_rom[idx_next];
            fr_ff    <= fr_in;
            use8_ff  <= use_in;
            lnum_ff  <= lnum_in;
            base9_ff <= base_ff;
            use9_ff  <= use8_ff;
            dprod_ff <= dprod_in;
            lprod_ff <= lprod_in;
            f_ff     <= f_in;
         end
      end

      assign f_out[g] = f_ff;
   end

   assign ctl_out = ctl10_ff;

endmodule

// ===== sv/s2l_lab_out.sv =====
// s2l_lab_out: form L*, a*, b*, round to the output fraction and saturate
// (two stages, the second is the output register). Depends on s2l_pkg.
module s2l_lab_out #(
   parameter int FRAC_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  s2l_pkg::ctl_type    ctl_in,
   input  logic [2:0][20:0]    f_in,
   output s2l_pkg::ctl_type    ctl_out,
   output logic [14:0]         lightness,
   output logic signed [15:0]  green_red,
   output logic signed [15:0]  blue_yellow
);

   localparam int OUT_SHIFT = 20 - FRAC_BITS;
   localparam logic [31:0] RND_HALF = 32'd1 << (OUT_SHIFT - 1);
   localparam logic signed [31:0] L_MAX = 32'sd100 <<< FRAC_BITS;
   localparam logic signed [31:0] SAT_LO = -32'sd32768;
   localparam logic signed [31:0] SAT_HI = 32'sd32767;

   function automatic logic signed [31:0] round_out(input logic signed [31:0] v);
      logic [31:0] mag;
      logic [31:0] q;
      mag = v[31] ? 32'(-v) : 32'(v);
      q = (mag + RND_HALF) >> OUT_SHIFT;
      return v[31] ? -$signed(q) : $signed(q);
   endfunction

   s2l_pkg::ctl_type ctl11_ff, ctl12_ff;

   logic [27:0]        lprod;
   logic [27:0]        lraw_in, lraw_ff;
   logic [21:0]        diff_a, diff_b;
   logic signed [31:0] araw_in, araw_ff, braw_in, braw_ff;
   logic signed [31:0] lv, av, bv;
   logic [14:0]        lightness_in, lightness_ff;
   logic signed [15:0] green_red_in, green_red_ff, blue_yellow_in, blue_yellow_ff;

   always_comb begin
      lprod   = {7'd0, f_in[1]} * 28'd116;
      lraw_in = lprod - 28'd16777216;
      diff_a  = {1'b0, f_in[0]} - {1'b0, f_in[1]};
      diff_b  = {1'b0, f_in[1]} - {1'b0, f_in[2]};
      araw_in = $signed({{10{diff_a[21]}}, diff_a}) * 32'sd500;
      braw_in = $signed({{10{diff_b[21]}}, diff_b}) * 32'sd200;

      lv = round_out($signed({{4{lraw_ff[27]}}, lraw_ff}));
      av = round_out(araw_ff);
      bv = round_out(braw_ff);

      // Black lands a hair below zero; clip to the valid L range
      if (lv < 32'sd0) lightness_in = '0;
      else if (lv > L_MAX) lightness_in = L_MAX[14:0];
      else lightness_in = lv[14:0];

      if (av < SAT_LO) green_red_in = SAT_LO[15:0];
      else if (av > SAT_HI) green_red_in = SAT_HI[15:0];
      else green_red_in = av[15:0];

      if (bv < SAT_LO) blue_yellow_in = SAT_LO[15:0];
      else if (bv > SAT_HI) blue_yellow_in = SAT_HI[15:0];
      else blue_yellow_in = bv[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl11_ff <= '0;
         ctl12_ff <= '0;
      end else if (adv) begin
         ctl11_ff <= ctl_in;
         ctl12_ff <= ctl11_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lraw_ff        <= lraw_in;
         araw_ff        <= araw_in;
         braw_ff        <= braw_in;
         lightness_ff   <= lightness_in;
         green_red_ff   <= green_red_in;
         blue_yellow_ff <= blue_yellow_in;
      end
   end

   assign ctl_out     = ctl12_ff;
   assign lightness   = lightness_ff;
   assign green_red   = green_red_ff;
   assign blue_yellow = blue_yellow_ff;

endmodule

// ===== sv/srgb_to_cielab_converter.sv =====
// srgb_to_cielab_converter: top level, 8-bit sRGB pixel to CIELAB (D65).
// Depends on s2l_pkg, s2l_if, s2l_gamma_matrix, s2l_ratio, s2l_cie_f, s2l_lab_out.
//
//   channel   | direction | payload                                     | handshake
//   ----------+-----------+---------------------------------------------+------------
//   req_ch    | in        | red, green, blue (8b each), last_in         | valid/ready
//   rsp_ch    | out       | lightness (15b), green_red, blue_yellow     | valid/ready
//             |           | (16b signed), last_out                      |
//
// One pixel enters per clock while no stall holds; its result passes through these
// register stages in turn: gamma, 2 matrix, 4 divide, root read, 2 interpolation,
// Lab forming, output register. Reset clears every stage valid bit; payload
// registers are not reset. A stall freezes the whole pipeline: while the output
// register holds an untaken result, req_ch.ready drops in the same cycle, so no
// transfer is lost or repeated. Bubbles travel as cleared valid bits.
module srgb_to_cielab_converter #(
   parameter int FRAC_BITS       = 8,
   parameter int ROOT_TABLE_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   s2l_req_if.sink           req_ch,
   s2l_rsp_if.source         rsp_ch
);

   s2l_pkg::ctl_type ctl_in;
   s2l_pkg::ctl_type ctl_gm, ctl_rt, ctl_f, ctl_out;
   logic [2:0][39:0] acc;
   logic [2:0][20:0] ratio;
   logic [2:0][20:0] fval;
   logic             adv;

   // Advance everything unless the output register holds an untaken result
   assign adv = !ctl_out.valid || rsp_ch.ready;

   assign req_ch.ready = adv;
   assign ctl_in = '{valid: req_ch.valid, last: req_ch.last_in};

   // Stages 1-3: gamma decode, matrix products, row sums
   s2l_gamma_matrix u_gamma_matrix (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_in  (ctl_in),
      .red     (req_ch.red),
      .green   (req_ch.green),
      .blue    (req_ch.blue),
      .ctl_out (ctl_gm),
      .acc_out (acc)
   );

   // Stages 4-7: white-point division to Q20 ratios
   s2l_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ctl_in    (ctl_gm),
      .acc_in    (acc),
      .ctl_out   (ctl_rt),
      .ratio_out (ratio)
   );

   // Stages 8-10: CIE f on each ratio
   s2l_cie_f #(
      .ROOT_TABLE_BITS (ROOT_TABLE_BITS)
   ) u_cie_f (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .ctl_in   (ctl_rt),
      .ratio_in (ratio),
      .ctl_out  (ctl_f),
      .f_out    (fval)
   );

   // Stages 11-12: L, a, b with rounding and saturation; stage 12 is the
   // output register seen on rsp_ch
   s2l_lab_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lab_out (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .ctl_in      (ctl_f),
      .f_in        (fval),
      .ctl_out     (ctl_out),
      .lightness   (rsp_ch.lightness),
      .green_red   (rsp_ch.green_red),
      .blue_yellow (rsp_ch.blue_yellow)
   );

   assign rsp_ch.valid    = ctl_out.valid;
   assign rsp_ch.last_out = ctl_out.last;

endmodule
